[sv/i2cm_pkg.sv]
// shared types, command codes and the pin level helper for the i2c master byte engine
package i2cm_pkg;

  // command codes carried by an input request
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // reset value of the half period register
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

  // bit count at which a byte is complete
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // bus sequencing phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START_A = 5'd1,
    PH_START_B = 5'd2,
    PH_START_C = 5'd3,
    PH_STOP_A  = 5'd4,
    PH_STOP_B  = 5'd5,
    PH_WR_HI   = 5'd6,
    PH_WR_LO   = 5'd7,
    PH_WA_HI   = 5'd8,
    PH_WA_LO   = 5'd9,
    PH_RD_HI   = 5'd10,
    PH_RD_LO   = 5'd11,
    PH_RA_HI   = 5'd12,
    PH_RA_LO   = 5'd13
  } phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_req_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } out_req_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

  // pin levels set on the first tick of a phase
  function automatic pins_t enter_pins(phase_t p, logic dbit, logic ackl, pins_t cur);
    pins_t res;
    res = cur;
    case (p)
      PH_START_A: res = '{scl: 1'b1, sda: 1'b1};
      PH_START_B: res = '{scl: 1'b1, sda: 1'b0};
      PH_START_C: res = '{scl: 1'b0, sda: 1'b0};
      PH_STOP_A:  res = '{scl: 1'b1, sda: 1'b0};
      PH_STOP_B:  res = '{scl: 1'b1, sda: 1'b1};
      PH_WR_HI:   res = '{scl: 1'b1, sda: dbit};
      PH_WR_LO:   res = '{scl: 1'b0, sda: dbit};
      PH_WA_HI:   res = '{scl: 1'b1, sda: 1'b1};
      PH_WA_LO:   res = '{scl: 1'b0, sda: 1'b1};
      PH_RD_HI:   res = '{scl: 1'b1, sda: 1'b1};
      PH_RD_LO:   res = '{scl: 1'b0, sda: 1'b1};
      PH_RA_HI:   res = '{scl: 1'b1, sda: ackl};
      PH_RA_LO:   res = '{scl: 1'b0, sda: ackl};
      default:    res = cur;
    endcase
    return res;
  endfunction

endpackage

[sv/i2cm_chan_if.sv]
// valid/ready channel carrying one payload request per handshake
interface i2cm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/i2c_master_byte_engine_core.sv]
// Tick-driven I2C master byte engine. Every input request is one time-base tick and yields
// exactly one result request with the pin levels, busy, done, the last received byte and the
// last ACK seen. Requests flow back to back, one per clock while the result side keeps up: a
// request is held in the input register, the sequencer step is then computed in a single pass
// and written to the result register. Commands are taken only while idle; the half period
// register (cfg channel, always ready) should be written while the engine is idle.
module i2c_master_byte_engine_core
  import i2cm_pkg::*;
#(
  parameter int DELAY_COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  i2cm_chan_if.sink    in_ch,
  i2cm_chan_if.source  out_ch,
  i2cm_chan_if.sink    cfg_ch
);

  localparam int DW = DELAY_COUNT_WIDTH;
  localparam int EW = (DW > 16) ? DW : 16;

  // configuration register
  logic [15:0] half_r;

  // input stage
  in_req_t in_r;
  logic    in_valid_r;

  // result stage
  out_req_t out_r;
  logic     out_valid_r;

  // sequencer state
  phase_t        phase_r, phase_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [DW-1:0] dc_r, dc_nxt;
  pins_t         pins_r, pins_nxt;
  logic [7:0]    rdres_r, rdres_nxt;
  logic          ackf_r, ackf_nxt;
  logic          acks_r, acks_nxt;

  // intermediate values after command acceptance
  phase_t        ph_a;
  logic          entered_a;
  logic [DW-1:0] dc_a, dc_dec, load;
  logic [3:0]    bit_a, bit_inc;
  logic [7:0]    shift_a;
  logic          acks_a;
  logic          expire;
  logic          done_w;

  logic [EW-1:0] h_ext, max_ext;
  logic          adv;

  // handshakes
  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // delay reload, zero treated as one, saturated to the counter
  always_comb begin
    h_ext   = EW'(half_r);
    max_ext = EW'({DW{1'b1}});
    load    = (h_ext > max_ext) ? max_ext[DW-1:0] : h_ext[DW-1:0];
    if (load == '0) begin
      load = DW'(1);
    end
  end

  // next phase: command acceptance then delay expiry
  always_comb begin
    ph_a    = phase_r;
    bit_a   = bit_r;
    shift_a = shift_r;
    acks_a  = acks_r;
    if (phase_r == PH_IDLE) begin
      case (in_r.command)
        CMD_START: ph_a = PH_START_A;
        CMD_STOP:  ph_a = PH_STOP_A;
        CMD_WRITE: begin
          ph_a    = PH_WR_HI;
          shift_a = in_r.tx_byte;
          bit_a   = '0;
        end
        CMD_READ: begin
          ph_a    = PH_RD_HI;
          shift_a = '0;
          bit_a   = '0;
          acks_a  = in_r.send_ack;
        end
        default: ph_a = PH_IDLE;
      endcase
    end
    entered_a = (phase_r == PH_IDLE) && (ph_a != PH_IDLE);
    dc_a      = entered_a ? load : dc_r;
    dc_dec    = (dc_a != '0) ? dc_a - DW'(1) : dc_a;
    expire    = (ph_a != PH_IDLE) && (dc_dec == '0);
    bit_inc   = bit_a + 4'd1;

    phase_nxt = ph_a;
    if (expire) begin
      case (ph_a)
        PH_START_A: phase_nxt = PH_START_B;
        PH_START_B: phase_nxt = PH_START_C;
        PH_STOP_A:  phase_nxt = PH_STOP_B;
        PH_WR_HI:   phase_nxt = PH_WR_LO;
        PH_WR_LO:   phase_nxt = (bit_inc >= BITS_PER_BYTE) ? PH_WA_HI : PH_WR_HI;
        PH_WA_HI:   phase_nxt = PH_WA_LO;
        PH_RD_HI:   phase_nxt = PH_RD_LO;
        PH_RD_LO:   phase_nxt = (bit_inc >= BITS_PER_BYTE) ? PH_RA_HI : PH_RD_HI;
        PH_RA_HI:   phase_nxt = PH_RA_LO;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and result for this tick
  always_comb begin
    pins_t p_a;
    bit_nxt   = bit_a;
    shift_nxt = shift_a;
    acks_nxt  = acks_a;
    ackf_nxt  = ackf_r;
    rdres_nxt = rdres_r;
    dc_nxt    = (ph_a != PH_IDLE) ? dc_dec : dc_r;
    p_a       = entered_a ? enter_pins(ph_a, shift_a[7], !acks_a, pins_r) : pins_r;
    pins_nxt  = p_a;
    done_w    = 1'b0;
    if (expire) begin
      case (ph_a)
        PH_WR_LO: begin
          shift_nxt = {shift_a[6:0], 1'b0};
          bit_nxt   = bit_inc;
        end
        PH_WA_HI: ackf_nxt = !in_r.sda_in;
        PH_RD_HI: shift_nxt = {shift_a[6:0], in_r.sda_in};
        PH_RD_LO: bit_nxt = bit_inc;
        PH_RA_LO: rdres_nxt = shift_a;
        default:  bit_nxt = bit_a;
      endcase
      if (phase_nxt != PH_IDLE) begin
        pins_nxt = enter_pins(phase_nxt, shift_nxt[7], !acks_nxt, p_a);
        dc_nxt   = load;
      end else begin
        done_w = 1'b1;
        if (ph_a == PH_RA_LO) begin
          pins_nxt.sda = 1'b1;
        end
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_PERIOD_RESET;
    end else if (cfg_ch.valid) begin
      half_r <= cfg_ch.data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.data;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.scl          <= pins_nxt.scl;
      out_r.sda_out      <= pins_nxt.sda;
      out_r.busy_res     <= (phase_nxt != PH_IDLE);
      out_r.done_res     <= done_w;
      out_r.rx_byte      <= rdres_nxt;
      out_r.ack_received <= ackf_nxt;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      shift_r <= '0;
      dc_r    <= '0;
      pins_r  <= '{scl: 1'b1, sda: 1'b1};
      rdres_r <= '0;
      ackf_r  <= 1'b0;
      acks_r  <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      dc_r    <= dc_nxt;
      pins_r  <= pins_nxt;
      rdres_r <= rdres_nxt;
      ackf_r  <= ackf_nxt;
      acks_r  <= acks_nxt;
    end
  end

endmodule

[verif/i2cm_byte_checker.sv]
// tick-by-tick bus predictor and result comparator for the i2c master byte engine
module i2cm_byte_checker
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_req_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_req_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted engine state
  logic [15:0] half_period;
  phase_t      seq_phase;
  logic [3:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [15:0] tick_cnt;
  logic        scl_lvl;
  logic        sda_lvl;
  logic [7:0]  rx_last;
  logic        ack_seen;
  logic        ack_drive;

  out_req_t bus_expected_q[$];
  int       err_cnt = 0;
  int       pending_cnt = 0;

  assign mismatches  = err_cnt;
  assign outstanding = pending_cnt;

  // pin levels of a new segment and its delay load; a zero half period counts as one tick
  task automatic load_segment(input phase_t p);
    logic dbit;
    logic ackl;
    dbit      = shifter[7];
    ackl      = ~ack_drive;
    seq_phase = p;
    case (p)
      PH_START_A: begin sda_lvl = 1'b1; scl_lvl = 1'b1; end
      PH_START_B: begin sda_lvl = 1'b0; scl_lvl = 1'b1; end
      PH_START_C: begin sda_lvl = 1'b0; scl_lvl = 1'b0; end
      PH_STOP_A:  begin sda_lvl = 1'b0; scl_lvl = 1'b1; end
      PH_STOP_B:  begin sda_lvl = 1'b1; scl_lvl = 1'b1; end
      PH_WR_HI:   begin sda_lvl = dbit; scl_lvl = 1'b1; end
      PH_WR_LO:   begin sda_lvl = dbit; scl_lvl = 1'b0; end
      PH_WA_HI:   begin sda_lvl = 1'b1; scl_lvl = 1'b1; end
      PH_WA_LO:   begin sda_lvl = 1'b1; scl_lvl = 1'b0; end
      PH_RD_HI:   begin sda_lvl = 1'b1; scl_lvl = 1'b1; end
      PH_RD_LO:   begin sda_lvl = 1'b1; scl_lvl = 1'b0; end
      PH_RA_HI:   begin sda_lvl = ackl; scl_lvl = 1'b1; end
      PH_RA_LO:   begin sda_lvl = ackl; scl_lvl = 1'b0; end
      default: ;
    endcase
    tick_cnt = (half_period == 16'd0) ? 16'd1 : half_period;
  endtask

  // one time-base tick: command pickup while idle, then the segment countdown
  task automatic advance_tick(input in_req_t r, output out_req_t res);
    logic fin;
    fin = 1'b0;
    if (seq_phase == PH_IDLE) begin
      case (r.command)
        CMD_START: load_segment(PH_START_A);
        CMD_STOP:  load_segment(PH_STOP_A);
        CMD_WRITE: begin
          shifter = r.tx_byte;
          bit_cnt = '0;
          load_segment(PH_WR_HI);
        end
        CMD_READ: begin
          shifter   = '0;
          bit_cnt   = '0;
          ack_drive = r.send_ack;
          load_segment(PH_RD_HI);
        end
        default: ;
      endcase
    end
    if (seq_phase != PH_IDLE) begin
      if (tick_cnt != 16'd0) tick_cnt = tick_cnt - 16'd1;
      if (tick_cnt == 16'd0) begin
        case (seq_phase)
          PH_START_A: load_segment(PH_START_B);
          PH_START_B: load_segment(PH_START_C);
          PH_STOP_A:  load_segment(PH_STOP_B);
          PH_WR_HI:   load_segment(PH_WR_LO);
          PH_WR_LO: begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 4'd1;
            load_segment(bit_cnt >= BITS_PER_BYTE ? PH_WA_HI : PH_WR_HI);
          end
          // slave ack sampled at the end of scl high
          PH_WA_HI: begin
            ack_seen = ~r.sda_in;
            load_segment(PH_WA_LO);
          end
          PH_RD_HI: begin
            shifter = {shifter[6:0], r.sda_in};
            load_segment(PH_RD_LO);
          end
          PH_RD_LO: begin
            bit_cnt = bit_cnt + 4'd1;
            load_segment(bit_cnt >= BITS_PER_BYTE ? PH_RA_HI : PH_RD_HI);
          end
          PH_RA_HI:   load_segment(PH_RA_LO);
          PH_RA_LO: begin
            rx_last   = shifter;
            sda_lvl   = 1'b1;
            seq_phase = PH_IDLE;
            fin       = 1'b1;
          end
          // last segment of start, stop and write ends here
          default: begin
            seq_phase = PH_IDLE;
            fin       = 1'b1;
          end
        endcase
      end
    end
    res = '{scl: scl_lvl, sda_out: sda_lvl, busy_res: (seq_phase != PH_IDLE), done_res: fin,
            rx_byte: rx_last, ack_received: ack_seen};
  endtask

  // predict on each accepted tick, compare each accepted result in order
  always @(posedge clk) begin : bus_check
    out_req_t pred;
    out_req_t want;
    if (!rst_n) begin
      half_period = HALF_PERIOD_RESET;
      seq_phase   = PH_IDLE;
      bit_cnt     = '0;
      shifter     = '0;
      tick_cnt    = '0;
      scl_lvl     = 1'b1;
      sda_lvl     = 1'b1;
      rx_last     = '0;
      ack_seen    = 1'b0;
      ack_drive   = 1'b0;
      bus_expected_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        advance_tick(in_data, pred);
        bus_expected_q.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (bus_expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result request with nothing pending: scl=%0b sda=%0b busy=%0b",
                     $realtime, out_data.scl, out_data.sda_out, out_data.busy_res);
        end else begin
          want = bus_expected_q.pop_front();
          if (out_data.scl !== want.scl || out_data.sda_out !== want.sda_out ||
              out_data.busy_res !== want.busy_res || out_data.done_res !== want.done_res ||
              out_data.rx_byte !== want.rx_byte ||
              out_data.ack_received !== want.ack_received) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: expected scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b",
                       $realtime, want.scl, want.sda_out, want.busy_res, want.done_res,
                       want.rx_byte, want.ack_received);
              $display("%0t: got      scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b",
                       $realtime, out_data.scl, out_data.sda_out, out_data.busy_res,
                       out_data.done_res, out_data.rx_byte, out_data.ack_received);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) half_period = cfg_data;
    end
    pending_cnt <= bus_expected_q.size();
  end

endmodule

[verif/tb_i2c_master_byte_engine_core.sv]
// top of the i2c master byte engine testbench: clock, reset, tick stimulus and verdict
module tb_i2c_master_byte_engine_core;
  import i2cm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4_000_000;

  typedef enum logic [1:0] {SDA_HOLD_LOW, SDA_HOLD_HIGH, SDA_RANDOM} sda_mode_t;

  logic clk;
  logic rst_n;

  i2cm_chan_if #(.T(in_req_t))     in_ch ();
  i2cm_chan_if #(.T(out_req_t))    out_ch ();
  i2cm_chan_if #(.T(logic [15:0])) cfg_ch ();

  int  tick_sent = 0;
  int  bus_results = 0;
  int  last_idle_idx = -1;
  int  cycles = 0;
  int  mismatches;
  int  outstanding;
  bit  calm = 1'b0;

  logic [2:0] cmd_pool [4] = '{CMD_START, CMD_STOP, CMD_WRITE, CMD_READ};

  i2c_master_byte_engine_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  i2cm_byte_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // count results and note the latest one that shows the engine idle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bus_results <= bus_results + 1;
      if (!out_ch.data.busy_res) last_idle_idx <= bus_results;
    end
  end

  // result side: random stalls, free-running stretches and one long hold-off
  // taken while the sender is offering requests
  initial begin : result_ready
    int  stall_left;
    int  mode_left;
    bit  free_run;
    bit  held;
    stall_left = 0;
    mode_left  = 0;
    free_run   = 1'b0;
    held       = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && tick_sent >= 800 && in_ch.valid) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (120) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(50, 300);
          free_run  = ($urandom_range(0, 2) == 0);
        end
        mode_left--;
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if (!free_run && $urandom_range(0, 99) < 25) begin
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(0, 2);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  function automatic logic pick_sda(sda_mode_t m);
    case (m)
      SDA_HOLD_LOW:  return 1'b0;
      SDA_HOLD_HIGH: return 1'b1;
      default:       return logic'($urandom_range(0, 1));
    endcase
  endfunction

  // offer one tick request, after a random gap unless in a calm stretch
  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
                           input logic sda);
    int gap;
    int r;
    r   = $urandom_range(0, 99);
    gap = (calm || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{command: cmd, tx_byte: tx, send_ack: ack, sda_in: sda};
    do @(posedge clk); while (!in_ch.ready);
    tick_sent++;
  endtask

  // idle ticks until a result issued after this point shows the engine idle
  task automatic settle(input sda_mode_t m);
    int mark;
    mark = tick_sent;
    while (last_idle_idx < mark)
      send_tick(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_sda(m));
  endtask

  task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
                         input sda_mode_t m);
    send_tick(cmd, tx, ack, pick_sda(m));
    settle(m);
  endtask

  // let every result come back, then reprogram the half period
  task automatic set_half_period(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (bus_results != tick_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // random ticks: mostly real commands, some idle ticks and unused codes
  task automatic random_ticks(input int n);
    int         r;
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 35)      cmd = CMD_NONE;
      else if (r < 88) cmd = cmd_pool[$urandom_range(0, 3)];
      else             cmd = 3'(CMD_READ + $urandom_range(1, 3));
      send_tick(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    calm = 1'b0;
    settle(SDA_RANDOM);
  endtask

  // stimulus and verdict
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset half period
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM);

    // directed at one tick per half period
    set_half_period(16'd1);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_HOLD_LOW);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_HOLD_HIGH);
    run_cmd(CMD_WRITE, 8'hA5, 1'b1, SDA_RANDOM);
    run_cmd(CMD_READ, 8'h00, 1'b1, SDA_HOLD_HIGH);
    run_cmd(CMD_READ, 8'hFF, 1'b0, SDA_HOLD_LOW);
    run_cmd(CMD_READ, 8'h5A, 1'b1, SDA_RANDOM);
    // unused codes act as no command
    for (int c = 1; c <= 3; c++) send_tick(3'(CMD_READ + c), 8'hFF, 1'b1, 1'b0);
    // commands offered on the finishing tick of start and of stop are dropped
    send_tick(CMD_START, 8'h00, 1'b0, 1'b1);
    send_tick(CMD_READ, 8'h00, 1'b1, 1'b1);
    send_tick(CMD_WRITE, 8'h3C, 1'b0, 1'b0);
    settle(SDA_RANDOM);
    send_tick(CMD_STOP, 8'h00, 1'b0, 1'b1);
    send_tick(CMD_READ, 8'h00, 1'b0, 1'b0);
    settle(SDA_RANDOM);

    // random phases over several half periods, zero among them
    set_half_period(16'd1);
    random_ticks(90);
    set_half_period(16'd2);
    random_ticks(90);
    set_half_period(16'd0);
    random_ticks(90);
    set_half_period(16'd3);
    random_ticks(90);
    set_half_period(16'd6);
    random_ticks(90);
    set_half_period(16'($urandom_range(1, 4)));
    random_ticks(90);

    // largest half period: a short stretch of a stop that keeps counting down
    set_half_period(16'hFFFF);
    send_tick(CMD_STOP, 8'h00, 1'b0, 1'b1);
    repeat (20) send_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);

    in_ch.valid <= 1'b0;
    while (bus_results != tick_sent) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/i2cm_pkg.sv
sv/i2cm_chan_if.sv
sv/i2c_master_byte_engine_core.sv
verif/i2cm_byte_checker.sv
verif/tb_i2c_master_byte_engine_core.sv
